[rtl/core/tcs_pkg.sv]
// shared types, fixed-point constants and series divisors for the cosine / sine unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tcs_pkg;

  // internal fraction bits of the sign / magnitude datapath
  localparam int unsigned INT_FRAC = 28;

  localparam int unsigned DEF_ANGLE_FRAC_BITS = 16;
  localparam int unsigned DEF_OUT_FRAC_BITS   = 16;

  // datapath widths
  localparam int unsigned R_W   = 30;  // folded remainder, at most pi
  localparam int unsigned X2_W  = 32;  // x squared, below 10.0
  localparam int unsigned P_W   = 29;  // horner partial value inside the series, 0..1.0
  localparam int unsigned Q_W   = 32;  // quotient of one horner step
  localparam int unsigned OUT_W = 18;

  localparam logic [Q_W-1:0] OUT_MAX = 32'd131071;

  localparam int unsigned HORNER_STEPS = 6;

  // constants rounded to nearest in Q.28
  localparam logic [31:0] ONE_Q     = 32'd1 << INT_FRAC;
  localparam logic [31:0] PI_Q      =
    32'(((64'd31415 << INT_FRAC) + 64'd5000) / 64'd10000);
  localparam logic [31:0] TWO_PI_Q  =
    32'(((64'd6283 << INT_FRAC) + 64'd500) / 64'd1000);
  localparam logic [31:0] HALF_PI_Q =
    32'(((64'd31415 << (INT_FRAC - 1)) + 64'd5000) / 64'd10000);

  typedef enum logic {
    REQ_COS = 1'b0,
    REQ_SIN = 1'b1
  } tcs_req_e;

  // control that travels with every pipeline stage
  typedef struct packed {
    logic valid;
    logic flip;
  } tcs_ctrl_t;

  // divisor of each nested step, innermost first
  function automatic int unsigned horner_div(input int unsigned k);
    int unsigned d;
    case (k)
      0: d = 132;
      1: d = 90;
      2: d = 56;
      3: d = 30;
      4: d = 12;
      5: d = 2;
      default: d = 2;
    endcase
    return d;
  endfunction

endpackage

[rtl/core/tcs_reduce.sv]
// range reduction: angle to Q.28, sine offset, reciprocal remainder against 2*pi, fold, square
// depends on tcs_pkg
`timescale 1ns / 1ps

module tcs_reduce #(
  parameter int unsigned ANGLE_FRAC_BITS = tcs_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic                      req_type_i,
  input  logic signed [31:0]        angle_i,
  output logic [tcs_pkg::X2_W-1:0]  x2_o,
  output tcs_pkg::tcs_ctrl_t        ctrl_o
);
  import tcs_pkg::*;

  localparam int unsigned SHIFT  = INT_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned MAG_W  = 32 + SHIFT;
  localparam int unsigned HI_W   = MAG_W - 30;  // magnitude bits at and above 2^30
  localparam int unsigned RCP_SH = 24;
  localparam int unsigned EST_W  = HI_W + RCP_SH;
  localparam int unsigned LO_W   = 33;          // partial remainder, below 3 * 2*pi
  // floor(2^54 / 2*pi), so the estimate never exceeds the true quotient
  localparam logic [RCP_SH-1:0] RCP_K =
    RCP_SH'((64'd1 << (30 + RCP_SH)) / 64'(TWO_PI_Q));
  localparam logic [LO_W-1:0] DIV_1 = LO_W'(TWO_PI_Q);
  localparam logic [LO_W-1:0] DIV_2 = LO_W'(TWO_PI_Q) << 1;

  logic signed [MAG_W:0] ang_ext;
  logic signed [MAG_W:0] x_sub;
  logic [MAG_W-1:0]      mag_d, mag_q;

  logic [HI_W-1:0]  mag_hi;
  logic [EST_W-1:0] est_prod;
  logic [HI_W-1:0]  est_d, est_q;
  logic [LO_W-1:0]  lo_q;
  logic [LO_W-1:0]  sub_d, sub_q;
  logic [30:0]      rem_d, rem_q;
  logic [3:0]       vld_q;

  // front: exact conversion, optional quarter-turn offset, absolute value
  always_comb begin
    ang_ext = (MAG_W+1)'(angle_i) <<< SHIFT;
    x_sub   = ang_ext - ((req_type_i == REQ_SIN) ? (MAG_W+1)'(HALF_PI_Q) : '0);
    mag_d   = x_sub[MAG_W] ? MAG_W'(-x_sub) : x_sub[MAG_W-1:0];
  end

  // quotient estimate from the upper bits, short of the true quotient by at most two
  always_comb begin
    mag_hi   = mag_q[MAG_W-1:30];
    est_prod = EST_W'(mag_hi) * EST_W'(RCP_K);
    est_d    = HI_W'(est_prod >> RCP_SH);
  end

  // back-multiply on the low bits only, the partial remainder is below 2^33
  always_comb begin
    sub_d = lo_q - LO_W'(est_q) * DIV_1;
  end

  // final correction by zero, one or two turns
  always_comb begin
    if (sub_q >= DIV_2) begin
      rem_d = 31'(sub_q - DIV_2);
    end else if (sub_q >= DIV_1) begin
      rem_d = 31'(sub_q - DIV_1);
    end else begin
      rem_d = sub_q[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      est_q <= est_d;
      lo_q  <= mag_q[LO_W-1:0];
      sub_q <= sub_d;
      rem_q <= rem_d;
    end
  end

  // fold the upper half turn down and remember the sign flip
  logic [30:0]  r_full;
  logic         fold_gt;
  logic [R_W-1:0] r_d, r_q;
  tcs_ctrl_t    fold_ctrl_d, fold_ctrl_q;

  always_comb begin
    r_full            = rem_q;
    fold_gt           = r_full > 31'(PI_Q);
    r_d               = fold_gt ? R_W'(r_full - 31'(PI_Q)) : r_full[R_W-1:0];
    fold_ctrl_d.valid = vld_q[3];
    fold_ctrl_d.flip  = fold_gt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_ctrl_q <= '0;
    end else if (en_i) begin
      fold_ctrl_q <= fold_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
    end
  end

  // square with round to nearest
  logic [2*R_W-1:0] sq;
  logic [X2_W-1:0]  x2_d, x2_q;
  tcs_ctrl_t        sq_ctrl_q;

  always_comb begin
    sq   = (2*R_W)'(r_q) * (2*R_W)'(r_q);
    x2_d = X2_W'((sq + ((2*R_W)'(1) << (INT_FRAC - 1))) >> INT_FRAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_ctrl_q <= '0;
    end else if (en_i) begin
      sq_ctrl_q <= fold_ctrl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q <= x2_d;
    end
  end

  assign x2_o   = x2_q;
  assign ctrl_o = sq_ctrl_q;

endmodule

[rtl/core/tcs_horner_step.sv]
// one nested series step: p = 1 - q_in, t = round(x2 * p), q_out = round(t / DIVISOR)
// depends on tcs_pkg; two register stages, divide by reciprocal multiply
`timescale 1ns / 1ps

module tcs_horner_step #(
  parameter int unsigned DIVISOR = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [tcs_pkg::X2_W-1:0]  x2_i,
  input  logic [tcs_pkg::Q_W-1:0]   q_i,
  input  tcs_pkg::tcs_ctrl_t        ctrl_i,
  output logic [tcs_pkg::X2_W-1:0]  x2_o,
  output logic [tcs_pkg::Q_W-1:0]   q_o,
  output tcs_pkg::tcs_ctrl_t        ctrl_o
);
  import tcs_pkg::*;

  localparam int unsigned PROD_W = X2_W + P_W;
  localparam int unsigned SH     = X2_W + $clog2(DIVISOR);
  localparam int unsigned RCP_W  = 2 * X2_W + 1;
  // exact floor division for any 32-bit numerator
  localparam logic [X2_W:0] RECIP =
    (X2_W+1)'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam logic [X2_W-1:0] HALF_D = X2_W'(DIVISOR / 2);

  // stage one: multiply
  logic [P_W-1:0]    p;
  logic [PROD_W-1:0] prod;
  logic [X2_W-1:0]   t_d, t_q, x2_s_q;
  tcs_ctrl_t         ctrl_s_q;

  always_comb begin
    p    = P_W'(ONE_Q) - q_i[P_W-1:0];
    prod = PROD_W'(x2_i) * PROD_W'(p);
    t_d  = X2_W'((prod + (PROD_W'(1) << (INT_FRAC - 1))) >> INT_FRAC);
  end

  // stage two: rounded divide
  logic [X2_W-1:0]  n;
  logic [RCP_W-1:0] qp;
  logic [Q_W-1:0]   q_d, q_q;
  logic [X2_W-1:0]  x2_q;
  tcs_ctrl_t        ctrl_q;

  always_comb begin
    n   = t_q + HALF_D;
    qp  = RCP_W'(n) * RCP_W'(RECIP);
    q_d = Q_W'(qp >> SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_s_q <= '0;
      ctrl_q   <= '0;
    end else if (en_i) begin
      ctrl_s_q <= ctrl_i;
      ctrl_q   <= ctrl_s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= t_d;
      x2_s_q <= x2_i;
      q_q    <= q_d;
      x2_q   <= x2_s_q;
    end
  end

  assign x2_o   = x2_q;
  assign q_o    = q_q;
  assign ctrl_o = ctrl_q;

endmodule

[rtl/core/tcs_output.sv]
// final subtract, sign, rounding to the output format, clamp and output skid register
// depends on tcs_pkg; drives the pipeline enable
`timescale 1ns / 1ps

module tcs_output #(
  parameter int unsigned OUT_FRAC_BITS = tcs_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [tcs_pkg::Q_W-1:0]          q_i,
  input  tcs_pkg::tcs_ctrl_t               ctrl_i,
  output logic                             en_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [tcs_pkg::OUT_W-1:0] value_o
);
  import tcs_pkg::*;

  localparam int unsigned RS = INT_FRAC - OUT_FRAC_BITS;
  localparam logic [Q_W-1:0] LIMIT =
    ((64'd1 << OUT_FRAC_BITS) > 64'(OUT_MAX)) ? OUT_MAX : Q_W'(64'd1 << OUT_FRAC_BITS);

  logic en;

  // stage one: p = 1 - q as sign and magnitude, then apply the fold flip
  logic [Q_W-1:0] pmag_d, pmag_q;
  logic           neg_d, neg_q;
  logic           vld_q;

  always_comb begin
    if (q_i > ONE_Q) begin
      pmag_d = q_i - ONE_Q;
      neg_d  = ~ctrl_i.flip;
    end else begin
      pmag_d = ONE_Q - q_i;
      neg_d  = ctrl_i.flip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pmag_q <= pmag_d;
      neg_q  <= neg_d;
    end
  end

  // stage two: round, clamp, sign
  logic [Q_W:0]     rsum;
  logic [Q_W-1:0]   mag, clamped, signed_val;
  logic [OUT_W-1:0] y_d;

  always_comb begin
    rsum       = {1'b0, pmag_q} + ((Q_W+1)'(1) << (RS - 1));
    mag        = Q_W'(rsum >> RS);
    clamped    = (mag > LIMIT) ? LIMIT : mag;
    signed_val = neg_q ? (Q_W'(0) - clamped) : clamped;
    y_d        = signed_val[OUT_W-1:0];
  end

  // output register plus skid entry
  logic             out_valid_d, out_valid_q;
  logic             skid_valid_d, skid_valid_q;
  logic [OUT_W-1:0] out_data_q, skid_data_q;
  logic             emit, out_open;

  assign en       = !skid_valid_q;
  assign emit     = vld_q && en;
  assign out_open = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_open) begin
      out_valid_d  = skid_valid_q || emit;
      skid_valid_d = 1'b0;
    end else if (emit) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_open) begin
      out_data_q <= skid_valid_q ? skid_data_q : y_d;
    end
    if (emit) begin
      skid_data_q <= y_d;
    end
  end

  assign en_o        = en;
  assign out_valid_o = out_valid_q;
  assign value_o     = out_data_q;

endmodule

[rtl/core/taylor_cosine_sine_unit.sv]
// cosine / sine of a fixed-point angle by a nested taylor series through x^12
// throughput: one request per cycle while in_stall_o is low; the whole pipeline advances
//   together and a skid entry at the output keeps in_stall_o registered, so a stalled result costs no slot
// reset: rst_ni is asynchronous and active low, clears every stage valid and the output valid
// depends on tcs_pkg, tcs_reduce, tcs_horner_step and tcs_output
`timescale 1ns / 1ps

module taylor_cosine_sine_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = tcs_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int unsigned OUT_FRAC_BITS   = tcs_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic signed [31:0]               angle_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [tcs_pkg::OUT_W-1:0] value_o
);
  import tcs_pkg::*;

  // common advance for all stages; low only while the skid entry is occupied
  logic en;

  // links between the horner steps; entry zero feeds the innermost step
  logic [X2_W-1:0] x2_link   [HORNER_STEPS+1];
  logic [Q_W-1:0]  q_link    [HORNER_STEPS+1];
  tcs_ctrl_t       ctrl_link [HORNER_STEPS+1];

  assign in_stall_o = !en;

  // angle to Q.28, remainder against 2*pi (reciprocal estimate, back-multiply,
  // correction), fold and square: six stages
  tcs_reduce #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .req_type_i (req_type_i),
    .angle_i    (angle_i),
    .x2_o       (x2_link[0]),
    .ctrl_o     (ctrl_link[0])
  );

  // innermost step starts from p = 1.0, that is a zero quotient
  assign q_link[0] = '0;

  // six nested steps, two stages each: multiply by x2, then divide by the step constant
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    tcs_horner_step #(
      .DIVISOR (horner_div(k))
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .x2_i   (x2_link[k]),
      .q_i    (q_link[k]),
      .ctrl_i (ctrl_link[k]),
      .x2_o   (x2_link[k+1]),
      .q_o    (q_link[k+1]),
      .ctrl_o (ctrl_link[k+1])
    );
  end

  // last subtract from 1.0, upper half turn sign flip, rounding, clamp to min(1.0, OUT_MAX)
  tcs_output #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q_link[HORNER_STEPS]),
    .ctrl_i      (ctrl_link[HORNER_STEPS]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

endmodule
